/* src/lcs_pkg.sv */
// Package for the LCS length and traceback block.
// Holds sizes, command and direction codes, FSM states and the cell link type.
// No dependencies.
package lcs_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int SYM_W   = 8;
  localparam int CMD_W   = 2;
  localparam int DIR_W   = 2;
  // fill runs until the last row has left the far end of the chain
  localparam int FILL_CYC = 2 * MAX_LEN + 2;
  localparam int CYC_W    = $clog2(FILL_CYC + 1);

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_APPEND_A = 2'd0;
  localparam cmd_t CMD_APPEND_B = 2'd1;
  localparam cmd_t CMD_COMPUTE  = 2'd2;

  typedef logic [DIR_W-1:0] dir_t;
  localparam dir_t DIR_DIAG = 2'd1;
  localparam dir_t DIR_UP   = 2'd2;
  localparam dir_t DIR_LEFT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_LEN,
    ST_TB_RD,
    ST_TB_USE,
    ST_EM_RD,
    ST_EM_OUT
  } state_t;

  // data handed from one cell to its right neighbor
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] left;
    logic [LEN_W-1:0] diag;
  } lcs_link_t;

endpackage

/* src/lcs_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/lcs_cell.sv */
// One column cell of the LCS systolic chain: holds a second-string symbol,
// the previous row value of its column and that column's direction RAM.
// Depends on lcs_pkg and lcs_ram.
module lcs_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  logic                     b_we,
  input  logic [lcs_pkg::SYM_W-1:0] b_data,
  input  lcs_pkg::lcs_link_t       link_i,
  output lcs_pkg::lcs_link_t       link_o,
  output logic [lcs_pkg::LEN_W-1:0] up_o,
  input  logic [lcs_pkg::IDX_W-1:0] dir_raddr,
  output lcs_pkg::dir_t            dir_rdata
);
  import lcs_pkg::*;

  logic [SYM_W-1:0] b_r;
  logic [LEN_W-1:0] up_r;
  logic             vld_r;
  logic [IDX_W-1:0] row_r;
  logic [SYM_W-1:0] sym_r;
  logic [LEN_W-1:0] left_r;
  logic [LEN_W-1:0] diag_r;
  logic [LEN_W-1:0] val_nxt;
  dir_t             dir_nxt;

  always_comb begin
    if (link_i.sym == b_r) begin
      val_nxt = link_i.diag + LEN_W'(1);
      dir_nxt = DIR_DIAG;
    end else if (up_r > link_i.left) begin
      val_nxt = up_r;
      dir_nxt = DIR_UP;
    end else begin
      val_nxt = link_i.left;
      dir_nxt = DIR_LEFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= link_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_r <= b_data;
    end
    if (clear) begin
      up_r <= '0;
    end else if (link_i.valid) begin
      up_r <= val_nxt;
    end
    row_r  <= link_i.row;
    sym_r  <= link_i.sym;
    left_r <= val_nxt;
    diag_r <= up_r;
  end

  assign link_o = '{valid: vld_r, row: row_r, sym: sym_r, left: left_r, diag: diag_r};
  assign up_o   = up_r;

  lcs_ram #(.WIDTH(DIR_W), .DEPTH(MAX_LEN)) u_dir (
    .clk   (clk),
    .we    (link_i.valid),
    .waddr (link_i.row),
    .wdata (dir_nxt),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

endmodule

/* src/lcs_length_and_traceback.sv */
// Top level of the LCS length and traceback block: string loading, the cell
// chain, traceback and result emission. Depends on lcs_pkg, lcs_ram, lcs_cell.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------
//  in      | in_command, in_symbol                   | in_valid / in_stall
//  out     | out_symbol, out_symbol_valid,           | out_valid / out_stall
//          | out_lcs_length, out_last, out_overflow  |
//
// Append transactions are taken while the block is idle. A compute fills the
// table while rows wave through the cell chain, then traces back one step per
// ST_TB_RD/ST_TB_USE pair (registered direction RAM reads), then emits one
// result per ST_EM_RD/ST_EM_OUT pair. in_stall is high from compute until
// the last result is in the output register; out_stall only delays emission.
// Reset (rst_n low, synchronous) empties both strings and clears the drop flag.
module lcs_length_and_traceback (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lcs_pkg::CMD_W-1:0] in_command,
  input  logic [lcs_pkg::SYM_W-1:0] in_symbol,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lcs_pkg::SYM_W-1:0] out_symbol,
  output logic                      out_symbol_valid,
  output logic [lcs_pkg::LEN_W-1:0] out_lcs_length,
  output logic                      out_last,
  output logic                      out_overflow
);
  import lcs_pkg::*;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] a_cnt_r, a_cnt_nxt, b_cnt_r, b_cnt_nxt;
  logic             drop_r, drop_nxt, ovf_r, ovf_nxt;
  logic [LEN_W-1:0] m_r, m_nxt, n_r, n_nxt;
  logic [CYC_W-1:0] t_r, t_nxt;
  logic [LEN_W-1:0] total_r, total_nxt, fill_r, fill_nxt;
  logic [LEN_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             feed_vld_r;
  logic [IDX_W-1:0] feed_row_r;
  logic             ov_r, ov_nxt;
  logic [SYM_W-1:0] osym_r, osym_nxt;
  logic             osv_r, osv_nxt, olast_r, olast_nxt;
  logic [LEN_W-1:0] olen_r, olen_nxt;
  logic             oovf_r, oovf_nxt;

  logic             in_acc, out_acc, clear;
  cmd_t             cmd;
  logic             a_we;
  logic [IDX_W-1:0] str_raddr, dir_raddr, jm1, seq_waddr;
  logic [SYM_W-1:0] str_rdata, seq_rdata;
  logic             seq_we;
  logic [LEN_W-1:0] len_val;
  dir_t             dir_sel;

  lcs_link_t        links [MAX_LEN+1];
  logic [LEN_W-1:0] ups   [MAX_LEN];
  dir_t             dirs  [MAX_LEN];

  assign cmd     = cmd_t'(in_command);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = ov_r && !out_stall;
  assign clear   = in_acc && (cmd == CMD_COMPUTE);
  assign a_we    = in_acc && (cmd == CMD_APPEND_A) && (a_cnt_r < LEN_W'(MAX_LEN));
  assign jm1     = IDX_W'(j_r - LEN_W'(1));
  assign dir_sel = dirs[jm1];
  assign len_val = (m_r == '0 || n_r == '0) ? '0 : ups[IDX_W'(n_r - LEN_W'(1))];
  assign str_raddr = (state_r == ST_FILL) ? t_r[IDX_W-1:0] : IDX_W'(i_r - LEN_W'(1));
  assign dir_raddr = IDX_W'(i_r - LEN_W'(1));

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_str_a (
    .clk(clk), .we(a_we), .waddr(a_cnt_r[IDX_W-1:0]), .wdata(in_symbol),
    .raddr(str_raddr), .rdata(str_rdata)
  );

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_seq (
    .clk(clk), .we(seq_we), .waddr(seq_waddr), .wdata(str_rdata),
    .raddr(k_r[IDX_W-1:0]), .rdata(seq_rdata)
  );

  // row feed into the head of the chain, zero left and diagonal boundary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_vld_r <= 1'b0;
    end else begin
      feed_vld_r <= (state_r == ST_FILL) && (CYC_W'(m_r) > t_r);
    end
    feed_row_r <= t_r[IDX_W-1:0];
  end

  assign links[0] = '{valid: feed_vld_r, row: feed_row_r, sym: str_rdata,
                      left: '0, diag: '0};

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    lcs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (clear),
      .b_we      (in_acc && (cmd == CMD_APPEND_B) && (b_cnt_r == LEN_W'(g))),
      .b_data    (in_symbol),
      .link_i    (links[g]),
      .link_o    (links[g+1]),
      .up_o      (ups[g]),
      .dir_raddr (dir_raddr),
      .dir_rdata (dirs[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      drop_r  <= 1'b0;
      ov_r    <= 1'b0;
      total_r <= '0;
      fill_r  <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      a_cnt_r <= a_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
      total_r <= total_nxt;
      fill_r  <= fill_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r   <= ovf_nxt;
    m_r     <= m_nxt;
    n_r     <= n_nxt;
    t_r     <= t_nxt;
    k_r     <= k_nxt;
    osym_r  <= osym_nxt;
    osv_r   <= osv_nxt;
    olen_r  <= olen_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    a_cnt_nxt = a_cnt_r;
    b_cnt_nxt = b_cnt_r;
    drop_nxt  = drop_r;
    ovf_nxt   = ovf_r;
    m_nxt     = m_r;
    n_nxt     = n_r;
    t_nxt     = t_r;
    total_nxt = total_r;
    fill_nxt  = fill_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    ov_nxt    = out_acc ? 1'b0 : ov_r;
    osym_nxt  = osym_r;
    osv_nxt   = osv_r;
    olen_nxt  = olen_r;
    olast_nxt = olast_r;
    oovf_nxt  = oovf_r;
    seq_we    = 1'b0;
    seq_waddr = IDX_W'(fill_r - LEN_W'(1));

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd == CMD_APPEND_A) begin
            if (a_cnt_r < LEN_W'(MAX_LEN)) a_cnt_nxt = a_cnt_r + LEN_W'(1);
            else drop_nxt = 1'b1;
          end else if (cmd == CMD_APPEND_B) begin
            if (b_cnt_r < LEN_W'(MAX_LEN)) b_cnt_nxt = b_cnt_r + LEN_W'(1);
            else drop_nxt = 1'b1;
          end else if (cmd == CMD_COMPUTE) begin
            m_nxt     = a_cnt_r;
            n_nxt     = b_cnt_r;
            ovf_nxt   = drop_r;
            a_cnt_nxt = '0;
            b_cnt_nxt = '0;
            drop_nxt  = 1'b0;
            t_nxt     = '0;
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        t_nxt = t_r + CYC_W'(1);
        if (t_r == CYC_W'(FILL_CYC)) state_nxt = ST_LEN;
      end
      ST_LEN: begin
        total_nxt = len_val;
        fill_nxt  = len_val;
        i_nxt     = m_r;
        j_nxt     = n_r;
        k_nxt     = '0;
        state_nxt = (len_val == '0) ? ST_EM_OUT : ST_TB_RD;
      end
      ST_TB_RD: begin
        if (i_r == '0 || j_r == '0) state_nxt = ST_EM_RD;
        else state_nxt = ST_TB_USE;
      end
      ST_TB_USE: begin
        state_nxt = ST_TB_RD;
        unique case (dir_sel)
          DIR_DIAG: begin
            if (fill_r != '0) begin
              seq_we   = 1'b1;
              fill_nxt = fill_r - LEN_W'(1);
            end
            i_nxt = i_r - LEN_W'(1);
            j_nxt = j_r - LEN_W'(1);
          end
          DIR_UP:  i_nxt = i_r - LEN_W'(1);
          default: j_nxt = j_r - LEN_W'(1);
        endcase
      end
      ST_EM_RD: state_nxt = ST_EM_OUT;
      ST_EM_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          osym_nxt  = (total_r == '0) ? '0 : seq_rdata;
          osv_nxt   = (total_r != '0);
          olen_nxt  = total_r;
          olast_nxt = (total_r == '0) || (k_r + LEN_W'(1) == total_r);
          oovf_nxt  = ovf_r;
          k_nxt     = k_r + LEN_W'(1);
          state_nxt = olast_nxt ? ST_IDLE : ST_EM_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid        = ov_r;
  assign out_symbol       = osym_r;
  assign out_symbol_valid = osv_r;
  assign out_lcs_length   = olen_r;
  assign out_last         = olast_r;
  assign out_overflow     = oovf_r;

  a_fill_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= total_r) else $error("traceback fill index beyond length");

  a_compute_enters_fill: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (state_r == ST_FILL)) else $error("compute did not start fill");

  a_tb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TB_USE) |-> (i_r != '0 && j_r != '0))
    else $error("traceback step at table edge");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    a_cnt_r <= LEN_W'(MAX_LEN) && b_cnt_r <= LEN_W'(MAX_LEN))
    else $error("string count past capacity");

endmodule
